// ----- hdl/frd_pkg.sv -----
// Shared types and codes for the radiator fan relay decision block.
package frd_pkg;

   // Status codes: which rule decided the relay command
   localparam logic [3:0] ST_FORCED_ON  = 4'd0;
   localparam logic [3:0] ST_CRANKING   = 4'd1;
   localparam logic [3:0] ST_STOPPED    = 4'd2;
   localparam logic [3:0] ST_TOO_FAST   = 4'd3;
   localparam logic [3:0] ST_BOARD_OFF  = 4'd4;
   localparam logic [3:0] ST_SENSOR_BAD = 4'd5;
   localparam logic [3:0] ST_PRESSURE   = 4'd6;
   localparam logic [3:0] ST_AC         = 4'd7;
   localparam logic [3:0] ST_HOT        = 4'd8;
   localparam logic [3:0] ST_COLD       = 4'd9;
   localparam logic [3:0] ST_HELD       = 4'd10;
   localparam logic [3:0] ST_BENCH      = 4'd11;

   // Control register indexes
   localparam logic [2:0] CSR_SPEED_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_SPEED_HYST    = 3'd1;
   localparam logic [2:0] CSR_FAN_ON_TEMP   = 3'd2;
   localparam logic [2:0] CSR_FAN_OFF_TEMP  = 3'd3;
   localparam logic [2:0] CSR_STOP_ENG_OFF  = 3'd4;
   localparam logic [2:0] CSR_AC_MODE       = 3'd5;
   localparam logic [2:0] CSR_PRESSURE_ON   = 3'd6;
   localparam logic [2:0] CSR_PRESSURE_OFF  = 3'd7;

   // A/C coupling modes
   localparam logic [1:0] AC_NONE     = 2'd0;
   localparam logic [1:0] AC_RELAY    = 2'd1;
   localparam logic [1:0] AC_PRESSURE = 2'd2;

   typedef struct packed {
      logic [7:0]         speed_limit;
      logic [7:0]         speed_hysteresis;
      logic signed [11:0] fan_on_temp;
      logic signed [11:0] fan_off_temp;
      logic               stop_when_engine_off;
      logic [1:0]         ac_mode;
      logic [11:0]        pressure_on;
      logic [11:0]        pressure_off;
   } cfg_type;

   typedef struct packed {
      logic               cranking;
      logic               running;
      logic               speed_valid;
      logic [7:0]         speed;
      logic               coolant_valid;
      logic signed [11:0] coolant_temp;
      logic               ac_active;
      logic               board_force_on;
      logic               board_inhibit;
      logic               pressure_valid;
      logic [11:0]        pressure;
      logic               bench_active;
   } req_type;

   typedef struct packed {
      logic       fan_on;
      logic [3:0] status;
      logic       speed_inh_next;
      logic       update_state;
   } dec_type;

endpackage

// ----- hdl/frd_csr.sv -----
// Control register file for the fan relay decision block.
module frd_csr (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [2:0]     wr_index,
   input  logic [11:0]    wr_data,
   output frd_pkg::cfg_type cfg
);

   frd_pkg::cfg_type cfg_ff;
   frd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            frd_pkg::CSR_SPEED_LIMIT:  cfg_in.speed_limit          = wr_data[7:0];
            frd_pkg::CSR_SPEED_HYST:   cfg_in.speed_hysteresis     = wr_data[7:0];
            frd_pkg::CSR_FAN_ON_TEMP:  cfg_in.fan_on_temp          = $signed(wr_data);
            frd_pkg::CSR_FAN_OFF_TEMP: cfg_in.fan_off_temp         = $signed(wr_data);
            frd_pkg::CSR_STOP_ENG_OFF: cfg_in.stop_when_engine_off = wr_data[0];
            frd_pkg::CSR_AC_MODE:      cfg_in.ac_mode              = wr_data[1:0];
            frd_pkg::CSR_PRESSURE_ON:  cfg_in.pressure_on          = wr_data;
            frd_pkg::CSR_PRESSURE_OFF: cfg_in.pressure_off         = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit          <= 8'd0;
         cfg_ff.speed_hysteresis     <= 8'd5;
         cfg_ff.fan_on_temp          <= 12'sd920;
         cfg_ff.fan_off_temp         <= 12'sd880;
         cfg_ff.stop_when_engine_off <= 1'b0;
         cfg_ff.ac_mode              <= frd_pkg::AC_NONE;
         cfg_ff.pressure_on          <= 12'd1400;
         cfg_ff.pressure_off         <= 12'd1100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/frd_decide.sv -----
// Priority chain that picks the fan relay command and status for one request.
module frd_decide (
   input  frd_pkg::req_type req,
   input  frd_pkg::cfg_type cfg,
   input  logic             fan_state,
   input  logic             speed_inh,
   output frd_pkg::dec_type dec
);

   logic signed [9:0] release_lvl;
   logic signed [9:0] speed_s;
   logic              speed_inh_upd;
   logic              by_pressure;

   assign release_lvl = $signed({2'b00, cfg.speed_limit}) - $signed({2'b00, cfg.speed_hysteresis});
   assign speed_s     = $signed({2'b00, req.speed});

   // speed inhibit latch with hysteresis; cleared when disabled or speed invalid
   always_comb begin
      speed_inh_upd = speed_inh;
      if ((cfg.speed_limit != 8'd0) && req.speed_valid) begin
         if (req.speed > cfg.speed_limit) begin
            speed_inh_upd = 1'b1;
         end else if (speed_s < release_lvl) begin
            speed_inh_upd = 1'b0;
         end
      end else begin
         speed_inh_upd = 1'b0;
      end
   end

   always_comb begin
      by_pressure = 1'b0;
      if ((cfg.ac_mode == frd_pkg::AC_PRESSURE) && req.pressure_valid) begin
         if (req.pressure >= cfg.pressure_on) begin
            by_pressure = 1'b1;
         end else if (req.pressure < cfg.pressure_off) begin
            by_pressure = 1'b0;
         end else begin
            by_pressure = fan_state;
         end
      end
   end

   always_comb begin
      dec.update_state   = 1'b1;
      dec.speed_inh_next = speed_inh_upd;
      dec.fan_on         = fan_state;
      dec.status         = frd_pkg::ST_HELD;
      if (req.bench_active) begin
         dec.update_state   = 1'b0;
         dec.speed_inh_next = speed_inh;
         dec.status         = frd_pkg::ST_BENCH;
      end else if (req.board_force_on) begin
         dec.speed_inh_next = speed_inh;
         dec.fan_on         = 1'b1;
         dec.status         = frd_pkg::ST_FORCED_ON;
      end else if (req.cranking) begin
         dec.fan_on = 1'b0;
         dec.status = frd_pkg::ST_CRANKING;
      end else if (!req.running && cfg.stop_when_engine_off) begin
         dec.fan_on = 1'b0;
         dec.status = frd_pkg::ST_STOPPED;
      end else if (speed_inh_upd) begin
         dec.fan_on = 1'b0;
         dec.status = frd_pkg::ST_TOO_FAST;
      end else if (req.board_inhibit) begin
         dec.fan_on = 1'b0;
         dec.status = frd_pkg::ST_BOARD_OFF;
      end else if (!req.coolant_valid) begin
         dec.fan_on = 1'b1;
         dec.status = frd_pkg::ST_SENSOR_BAD;
      end else if (by_pressure) begin
         dec.fan_on = 1'b1;
         dec.status = frd_pkg::ST_PRESSURE;
      end else if ((cfg.ac_mode == frd_pkg::AC_RELAY) && req.ac_active) begin
         dec.fan_on = 1'b1;
         dec.status = frd_pkg::ST_AC;
      end else if (req.coolant_temp > cfg.fan_on_temp) begin
         dec.fan_on = 1'b1;
         dec.status = frd_pkg::ST_HOT;
      end else if (req.coolant_temp < cfg.fan_off_temp) begin
         dec.fan_on = 1'b0;
         dec.status = frd_pkg::ST_COLD;
      end
   end

endmodule

// ----- hdl/fan_relay_decision_unit.sv -----
// Top level of the radiator fan relay decision block.
//
// Usage:
//  - req_* channel: one request per periodic sensor tick, accepted at a rising
//    edge with req_valid high and req_stall low.
//  - rsp_* channel: exactly one result per request (fan_on, status), in order,
//    taken at a rising edge with rsp_valid high and rsp_stall low.
//  - csr_* channel: register writes, always ready; write only while idle.
//  - Pipeline: a request in the input register is decided there and its result is
//    registered for rsp_*, two register stages in all (input and result).
//  - Throughput: one request per cycle unless rsp_stall holds the result register,
//    set by the combinational decision path; fan_state and the speed latch
//    update as each non-bench request is decided, so the next sees them at once.
//  - Stall: when the result register is held by rsp_stall, the request in the
//    input register waits and req_stall rises; both registers stay full.
//  - Reset (synchronous): empties both stages, clears fan_state and the speed
//    inhibit latch, and loads the control register defaults.
module fan_relay_decision_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cranking,
   input  logic               req_running,
   input  logic               req_speed_valid,
   input  logic [7:0]         req_speed,
   input  logic               req_coolant_valid,
   input  logic signed [11:0] req_coolant_temp,
   input  logic               req_ac_active,
   input  logic               req_board_force_on,
   input  logic               req_board_inhibit,
   input  logic               req_pressure_valid,
   input  logic [11:0]        req_pressure,
   input  logic               req_bench_active,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_fan_on,
   output logic [3:0]         rsp_status,
   // control register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   frd_pkg::cfg_type cfg;
   frd_pkg::req_type req_ff;
   frd_pkg::dec_type dec;

   logic       req_vld_ff;
   logic       rsp_vld_ff;
   logic       fan_state_ff;
   logic       speed_inh_ff;
   logic       rsp_fan_ff;
   logic [3:0] rsp_status_ff;

   logic       rsp_free;   // result register can take a new result
   logic       fire;       // request in input register is decided this cycle
   logic       req_take;

   assign csr_ready = 1'b1;

   frd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   frd_decide u_decide (
      .req       (req_ff),
      .cfg       (cfg),
      .fan_state (fan_state_ff),
      .speed_inh (speed_inh_ff),
      .dec       (dec)
   );

   assign rsp_free  = !rsp_vld_ff || !rsp_stall;
   assign fire      = req_vld_ff && rsp_free;
   assign req_stall = req_vld_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   // control: stage valids and decision state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         fan_state_ff <= 1'b0;
         speed_inh_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_vld_ff <= req_valid;
         end
         if (rsp_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (fire && dec.update_state) begin
            fan_state_ff <= dec.fan_on;
            speed_inh_ff <= dec.speed_inh_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.cranking       <= req_cranking;
         req_ff.running        <= req_running;
         req_ff.speed_valid    <= req_speed_valid;
         req_ff.speed          <= req_speed;
         req_ff.coolant_valid  <= req_coolant_valid;
         req_ff.coolant_temp   <= req_coolant_temp;
         req_ff.ac_active      <= req_ac_active;
         req_ff.board_force_on <= req_board_force_on;
         req_ff.board_inhibit  <= req_board_inhibit;
         req_ff.pressure_valid <= req_pressure_valid;
         req_ff.pressure       <= req_pressure;
         req_ff.bench_active   <= req_bench_active;
      end
      if (fire) begin
         rsp_fan_ff    <= dec.fan_on;
         rsp_status_ff <= dec.status;
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_fan_on = rsp_fan_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- tb/sv/fan_relay_checker.sv -----
`timescale 1ns / 1ps
// Checker for the fan relay decision block: predicts each relay command and compares.
module fan_relay_checker
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_fan_on,
   input  logic [3:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata,
   output int          fail_count,
   output int          results_owed
);

   typedef struct packed {
      logic       fan_on;
      logic [3:0] status;
   } relay_cmd_type;

   cfg_type       regs;
   logic          fan_state;
   logic          speed_latch;
   relay_cmd_type relay_cmd_q[$];
   int            errs = 0;

   // Updates fan_state and the speed latch the way the block does per request.
   function automatic relay_cmd_type decide_relay(input req_type r);
      relay_cmd_type c;
      logic          by_pressure;
      int            lim;
      int            spd;
      int            temp;
      int            t_on;
      int            t_off;
      if (r.bench_active) begin
         c.fan_on = fan_state;
         c.status = ST_BENCH;
         return c;
      end
      if (r.board_force_on) begin
         c.fan_on = 1'b1;
         c.status = ST_FORCED_ON;
      end else begin
         lim = int'(regs.speed_limit);
         spd = int'(r.speed);
         if (lim > 0 && r.speed_valid) begin
            if (spd > lim)
               speed_latch = 1'b1;
            else if (spd < lim - int'(regs.speed_hysteresis))
               speed_latch = 1'b0;
         end else begin
            speed_latch = 1'b0;
         end
         temp  = int'($signed(r.coolant_temp));
         t_on  = int'($signed(regs.fan_on_temp));
         t_off = int'($signed(regs.fan_off_temp));
         if (r.cranking) begin
            c = '{1'b0, ST_CRANKING};
         end else if (!r.running && regs.stop_when_engine_off) begin
            c = '{1'b0, ST_STOPPED};
         end else if (speed_latch) begin
            c = '{1'b0, ST_TOO_FAST};
         end else if (r.board_inhibit) begin
            c = '{1'b0, ST_BOARD_OFF};
         end else if (!r.coolant_valid) begin
            c = '{1'b1, ST_SENSOR_BAD};
         end else begin
            by_pressure = 1'b0;
            if (regs.ac_mode == AC_PRESSURE && r.pressure_valid) begin
               if (r.pressure >= regs.pressure_on)
                  by_pressure = 1'b1;
               else if (r.pressure < regs.pressure_off)
                  by_pressure = 1'b0;
               else
                  by_pressure = fan_state;
            end
            if (by_pressure)
               c = '{1'b1, ST_PRESSURE};
            else if (regs.ac_mode == AC_RELAY && r.ac_active)
               c = '{1'b1, ST_AC};
            else if (temp > t_on)
               c = '{1'b1, ST_HOT};
            else if (temp < t_off)
               c = '{1'b0, ST_COLD};
            else
               c = '{fan_state, ST_HELD};
         end
      end
      fan_state = c.fan_on;
      return c;
   endfunction

   always @(posedge clock) begin
      relay_cmd_type want;
      if (reset) begin
         regs.speed_limit          = 8'd0;
         regs.speed_hysteresis     = 8'd5;
         regs.fan_on_temp          = 12'sd920;
         regs.fan_off_temp         = 12'sd880;
         regs.stop_when_engine_off = 1'b0;
         regs.ac_mode              = AC_NONE;
         regs.pressure_on          = 12'd1400;
         regs.pressure_off         = 12'd1100;
         fan_state                 = 1'b0;
         speed_latch               = 1'b0;
         relay_cmd_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (relay_cmd_q.size() == 0) begin
               errs++;
               $display("%0t: unexpected result, expected none actual fan_on %0d status %0d",
                        $time, rsp_fan_on, rsp_status);
            end else begin
               want = relay_cmd_q.pop_front();
               if (rsp_fan_on !== want.fan_on) begin
                  errs++;
                  $display("%0t: fan_on mismatch, expected %0d actual %0d",
                           $time, want.fan_on, rsp_fan_on);
               end
               if (rsp_status !== want.status) begin
                  errs++;
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPEED_LIMIT:  regs.speed_limit          = csr_wdata[7:0];
               CSR_SPEED_HYST:   regs.speed_hysteresis     = csr_wdata[7:0];
               CSR_FAN_ON_TEMP:  regs.fan_on_temp          = csr_wdata;
               CSR_FAN_OFF_TEMP: regs.fan_off_temp         = csr_wdata;
               CSR_STOP_ENG_OFF: regs.stop_when_engine_off = csr_wdata[0];
               CSR_AC_MODE:      regs.ac_mode              = csr_wdata[1:0];
               CSR_PRESSURE_ON:  regs.pressure_on          = csr_wdata;
               CSR_PRESSURE_OFF: regs.pressure_off         = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            relay_cmd_q.push_back(decide_relay(req));
      end
      fail_count   <= errs;
      results_owed <= relay_cmd_q.size();
   end

endmodule

// ----- tb/sv/tb_fan_relay_decision_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the fan relay decision block: stimulus, idling and verdict.
module tb_fan_relay_decision_unit;
   import frd_pkg::*;

   // no cycle without a handshake should last this long, even in the hold-off
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 470;
   // mode value with no coupling defined; the block must treat it as none
   localparam logic [1:0] AC_UNUSED = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_item  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_fan_on;
   logic [3:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   logic        rsp_hold  = 1'b0;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          idle_cycles = 0;
   int          fail_count;
   int          results_owed;
   cfg_type     cur_cfg;
   req_type     r;

   always #5 clock = ~clock;

   fan_relay_decision_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cranking       (req_item.cranking),
      .req_running        (req_item.running),
      .req_speed_valid    (req_item.speed_valid),
      .req_speed          (req_item.speed),
      .req_coolant_valid  (req_item.coolant_valid),
      .req_coolant_temp   (req_item.coolant_temp),
      .req_ac_active      (req_item.ac_active),
      .req_board_force_on (req_item.board_force_on),
      .req_board_inhibit  (req_item.board_inhibit),
      .req_pressure_valid (req_item.pressure_valid),
      .req_pressure       (req_item.pressure),
      .req_bench_active   (req_item.bench_active),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fan_on         (rsp_fan_on),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   fan_relay_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req          (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_fan_on   (rsp_fan_on),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   // Receiver: random stalls, plus the long hold-off while rsp_hold is up.
   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
   end

   // Watchdog: counts cycles without any handshake on any channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_fan_relay_decision_unit NOT OK");
         $finish;
      end
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic cfg_type mk_cfg(input int lim, input int hy, input int t_on,
                                      input int t_off, input int stop, input logic [1:0] ac,
                                      input int p_on, input int p_off);
      cfg_type c;
      c.speed_limit          = 8'(lim);
      c.speed_hysteresis     = 8'(hy);
      c.fan_on_temp          = 12'(t_on);
      c.fan_off_temp         = 12'(t_off);
      c.stop_when_engine_off = 1'(stop);
      c.ac_mode              = ac;
      c.pressure_on          = 12'(p_on);
      c.pressure_off         = 12'(p_off);
      return c;
   endfunction

   // Random setting; the limits and thresholds hit their extremes now and then.
   function automatic cfg_type rand_cfg();
      int lim, hy, t_on, t_off, p_on, p_off, pick;
      pick = int'($urandom_range(9));
      lim  = (pick < 2) ? 0 : ((pick == 2) ? 255 : int'($urandom_range(20, 200)));
      pick = int'($urandom_range(9));
      hy   = (pick == 0) ? 0 : ((pick == 1) ? 255 : int'($urandom_range(30)));
      t_on = int'($urandom_range(1900)) - 400;
      if ($urandom_range(3) == 0)
         t_off = int'($urandom_range(1900)) - 400;   // thresholds may cross
      else
         t_off = clamp(t_on - int'($urandom_range(100)), -400, 1500);
      p_on = int'($urandom_range(4095));
      if ($urandom_range(3) == 0)
         p_off = int'($urandom_range(4095));
      else
         p_off = clamp(p_on - int'($urandom_range(800)), 0, 4095);
      return mk_cfg(lim, hy, t_on, t_off, int'($urandom_range(1)), 2'($urandom_range(3)),
                    p_on, p_off);
   endfunction

   // Quiet running engine at a mild temperature; directed items tweak from here.
   function automatic req_type base_item();
      req_type b;
      b = '0;
      b.running       = 1'b1;
      b.speed_valid   = 1'b1;
      b.coolant_valid = 1'b1;
      b.coolant_temp  = 12'sd900;
      b.pressure      = 12'd1000;
      return b;
   endfunction

   // Random tick: speed, temperature and pressure cluster around the current
   // thresholds half the time so the hysteresis bands are really exercised.
   function automatic req_type rand_item();
      req_type x;
      int lim, hy, s, t, p;
      x.cranking       = ($urandom_range(99) < 6);
      x.running        = ($urandom_range(99) < 85);
      x.speed_valid    = ($urandom_range(99) < 90);
      x.coolant_valid  = ($urandom_range(99) < 94);
      x.ac_active      = 1'($urandom_range(1));
      x.board_force_on = ($urandom_range(99) < 7);
      x.board_inhibit  = ($urandom_range(99) < 7);
      x.pressure_valid = ($urandom_range(99) < 85);
      x.bench_active   = ($urandom_range(99) < 5);
      lim = int'(cur_cfg.speed_limit);
      hy  = int'(cur_cfg.speed_hysteresis);
      if (lim > 0 && $urandom_range(1))
         s = clamp(lim - hy - 3 + int'($urandom_range(hy + 6)), 0, 255);
      else
         s = int'($urandom_range(255));
      x.speed = 8'(s);
      case ($urandom_range(3))
         0:       t = int'($signed(cur_cfg.fan_on_temp)) + int'($urandom_range(6)) - 3;
         1:       t = int'($signed(cur_cfg.fan_off_temp)) + int'($urandom_range(6)) - 3;
         default: t = int'($urandom_range(1900)) - 400;
      endcase
      x.coolant_temp = 12'(clamp(t, -400, 1500));
      case ($urandom_range(3))
         0:       p = int'(cur_cfg.pressure_on) + int'($urandom_range(6)) - 3;
         1:       p = int'(cur_cfg.pressure_off) + int'($urandom_range(6)) - 3;
         default: p = int'($urandom_range(4095));
      endcase
      x.pressure = 12'(clamp(p, 0, 4095));
      return x;
   endfunction

   task automatic send_req(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_regs(input cfg_type c);
      cur_cfg = c;
      write_reg(CSR_SPEED_LIMIT,  {4'd0, c.speed_limit});
      write_reg(CSR_SPEED_HYST,   {4'd0, c.speed_hysteresis});
      write_reg(CSR_FAN_ON_TEMP,  c.fan_on_temp);
      write_reg(CSR_FAN_OFF_TEMP, c.fan_off_temp);
      write_reg(CSR_STOP_ENG_OFF, {11'd0, c.stop_when_engine_off});
      write_reg(CSR_AC_MODE,      {10'd0, c.ac_mode});
      write_reg(CSR_PRESSURE_ON,  c.pressure_on);
      write_reg(CSR_PRESSURE_OFF, c.pressure_off);
      csr_valid <= 1'b0;
   endtask

   // Drain: stop offering, wait for every owed result, then cover the two
   // register stages before touching the registers.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Relay-coupled A/C, engine-off inhibit on, speed limit 100 with band 10.
      set_regs(mk_cfg(100, 10, 920, 880, 1, AC_RELAY, 1400, 1100));
      r = base_item(); r.coolant_temp = 12'sd1500;  send_req(r);   // hot, fan on
      r = base_item(); r.bench_active = 1'b1;        send_req(r);   // bench repeats fan
      r = base_item(); r.coolant_temp = -12'sd400;  send_req(r);   // cold
      r = base_item();                               send_req(r);   // held in band
      r = base_item(); r.ac_active = 1'b1;           send_req(r);   // relay A/C
      r = base_item(); r.cranking = 1'b1;            send_req(r);
      r = base_item(); r.running = 1'b0;             send_req(r);   // engine stopped
      r = base_item(); r.speed = 8'd255;             send_req(r);   // latch sets
      r = base_item(); r.speed = 8'd95;              send_req(r);   // inside band, holds
      r = base_item(); r.board_force_on = 1'b1;      send_req(r);   // latch untouched
      r = base_item(); r.speed = 8'd95;              send_req(r);   // still inhibited
      r = base_item(); r.speed = 8'd89;              send_req(r);   // below band, releases
      r = base_item(); r.board_inhibit = 1'b1;       send_req(r);
      r = base_item(); r.coolant_valid = 1'b0;       send_req(r);   // broken sensor
      r = base_item(); r.speed_valid = 1'b0; r.speed = 8'd255; send_req(r);
      settle();

      // Pressure mode, hysteresis wider than the limit, crossed temperatures.
      set_regs(mk_cfg(200, 255, -400, 1500, 0, AC_PRESSURE, 4095, 0));
      r = base_item(); r.pressure_valid = 1'b1; r.pressure = 12'd4095; send_req(r);
      r = base_item(); r.pressure_valid = 1'b1; r.pressure = 12'd2000; send_req(r); // band
      r = base_item(); r.coolant_temp = -12'sd400;   send_req(r);   // no pressure reading
      r = base_item(); r.speed = 8'd255;             send_req(r);   // latch sets
      r = base_item(); r.speed = 8'd0;               send_req(r);   // never releases
      r = base_item(); r.speed_valid = 1'b0;         send_req(r);   // invalid speed clears
      settle();

      // Unused A/C mode, speed inhibit disabled.
      set_regs(mk_cfg(0, 0, 920, 880, 0, AC_UNUSED, 0, 4095));
      r = base_item(); r.ac_active = 1'b1; r.pressure_valid = 1'b1; send_req(r);
      r = base_item(); r.speed = 8'd255; r.running = 1'b0;          send_req(r);

      // Random phases, one idling style each.
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         set_regs(rand_cfg());
         case (ph)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
               // long receiver hold-off while requests keep coming
               fork
                  begin
                     rsp_hold <= 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     rsp_hold <= 1'b0;
                  end
               join_none
            end
            1: begin idle_pct = 63; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 63; end
            default: begin idle_pct = 17; stall_pct <= 17; end
         endcase
         repeat (PHASE_ITEMS) send_req(rand_item());
      end
      settle();
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("tb_fan_relay_decision_unit OK");
      else
         $display("tb_fan_relay_decision_unit NOT OK");
      $finish;
   end

endmodule
